[rtl/room_thermostat_controller_defines.svh]
// Assertion shorthands used by the checker of the thermostat block.
// Each expects clk and rst_n in scope.
`ifndef ROOM_THERMOSTAT_CONTROLLER_DEFINES_SVH
`define ROOM_THERMOSTAT_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define RTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rtc_pkg.sv]
package rtc_pkg;

  localparam int ADC_BITS = 10;
  localparam int FULL     = (1 << ADC_BITS) - 1;

  localparam int TIME_W   = 32;
  localparam int TEMP_W   = 12;
  localparam int KNOB_W   = 10;
  localparam int LIGHT_W  = 10;
  localparam int SET_W    = 9;
  localparam int PER_W    = 16;
  localparam int HYST_W   = 7;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W   = 19;

  typedef enum logic [1:0] {
    MODE_FAN   = 2'd0,
    MODE_ALARM = 2'd1,
    MODE_LIGHT = 2'd2
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST     = 3'd5;

  localparam logic [PER_W-1:0]   DEBOUNCE_RST = 16'd50;
  localparam logic [KNOB_W-1:0]  DEADBAND_RST = 10'd5;
  localparam logic [PER_W-1:0]   BLINK_RST    = 16'd300;
  localparam logic [PER_W-1:0]   LIGHT_RST    = 16'd200;
  localparam logic [PER_W-1:0]   REPORT_RST   = 16'd1000;
  localparam logic [HYST_W-1:0]  HYST_RST     = 7'd10;

  localparam logic [SET_W-1:0]   FAN_THR_RST   = 9'd250;
  localparam logic [SET_W-1:0]   COLD_THR_RST  = 9'd150;
  localparam logic [LIGHT_W-1:0] LIGHT_THR_RST = 10'd400;

  localparam logic [SET_W-1:0] FAN_BASE  = 9'd180;
  localparam logic [SET_W-1:0] COLD_BASE = 9'd100;
  localparam logic [7:0]       FAN_SPAN  = 8'd170;
  localparam logic [7:0]       COLD_SPAN = 8'd250;

  // ceil(knob * span / FULL); FULL is 2^ADC_BITS - 1, so the quotient comes from
  // the top bits plus one correction step
  function automatic logic [7:0] scale_up(input logic [KNOB_W-1:0] knob,
                                          input logic [7:0] span);
    logic [KNOB_W-1:0] kn;
    logic [PROD_W-1:0] n;
    logic [PROD_W-1:0] q0;
    logic [PROD_W-1:0] r;
    kn = (32'(knob) > 32'(FULL)) ? KNOB_W'(FULL) : knob;
    n  = PROD_W'(kn) * PROD_W'(span) + PROD_W'(FULL - 1);
    q0 = n >> ADC_BITS;
    r  = (n & PROD_W'(FULL)) + q0;
    scale_up = 8'(q0) + ((r >= PROD_W'(FULL)) ? 8'd1 : 8'd0);
  endfunction

endpackage

[rtl/room_thermostat_controller.sv]
// Channel  | Ports                                         | Dir | Handshake
// ---------+-----------------------------------------------+-----+------------------
// sample   | in_now_ms, in_temperature, in_knob_code,      | in  | in_valid/in_stall
//          | in_button_pressed, in_light_level             |     |
// result   | out_fan_on ... out_light_setpoint             | out | out_valid/out_stall
// config   | cfg_we, cfg_index, cfg_wdata                  | in  | write only
//
// One sample per cycle sustained while out_stall is low; each sample goes into the
// input register, then its result word into the result register, where it is valid.
// Synchronous reset restores the register defaults and the controller state; the knob reference is only marked invalid.
// out_stall holds the result register; the input register still takes one more
// sample, and in_stall rises only when both registers are full.
module room_thermostat_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rtc_pkg::TIME_W-1:0]        in_now_ms,
  input  logic signed [rtc_pkg::TEMP_W-1:0] in_temperature,
  input  logic [rtc_pkg::KNOB_W-1:0]        in_knob_code,
  input  logic                              in_button_pressed,
  input  logic [rtc_pkg::LIGHT_W-1:0]       in_light_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_fan_on,
  output logic                              out_alarm_led,
  output logic                              out_lights_on,
  output logic [1:0]                        out_adjust_mode,
  output logic                              out_mode_changed,
  output logic                              out_report_due,
  output logic [rtc_pkg::SET_W-1:0]         out_fan_setpoint,
  output logic [rtc_pkg::SET_W-1:0]         out_cold_setpoint,
  output logic [rtc_pkg::LIGHT_W-1:0]       out_light_setpoint,
  input  logic                              cfg_we,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtc_pkg::CFG_W-1:0]         cfg_wdata
);
  import rtc_pkg::*;

  // configuration
  logic [PER_W-1:0]  debounce_r, blink_per_r, light_per_r, report_per_r;
  logic [KNOB_W-1:0] deadband_r;
  logic [HYST_W-1:0] hyst_r;

  // input register
  logic                     s1_valid_r, s1_valid_nxt;
  logic [TIME_W-1:0]        now_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [KNOB_W-1:0]        knob_r;
  logic                     button_r;
  logic [LIGHT_W-1:0]       light_r;
  logic [SET_W-1:0]         fan_cand_r, cold_cand_r;

  // controller state
  mode_t              mode_r, mode_nxt;
  logic               button_last_r, button_last_nxt;
  logic [TIME_W-1:0]  debounce_stamp_r, debounce_stamp_nxt;
  logic [KNOB_W-1:0]  knob_ref_r, knob_ref_nxt;
  logic               knob_ref_valid_r;
  logic [SET_W-1:0]   fan_thr_r, fan_thr_nxt;
  logic [SET_W-1:0]   cold_thr_r, cold_thr_nxt;
  logic [LIGHT_W-1:0] light_thr_r, light_thr_nxt;
  logic               fan_state_r, fan_state_nxt;
  logic               led_state_r, led_state_nxt;
  logic [TIME_W-1:0]  blink_stamp_r, blink_stamp_nxt;
  logic [TIME_W-1:0]  light_stamp_r, light_stamp_nxt;
  logic               lights_state_r, lights_state_nxt;
  logic [TIME_W-1:0]  report_stamp_r, report_stamp_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic               out_fan_r, out_led_r, out_lights_r;
  mode_t              out_mode_r;
  logic               out_mode_chg_r, out_report_r;
  logic [SET_W-1:0]   out_fan_thr_r, out_cold_thr_r;
  logic [LIGHT_W-1:0] out_light_thr_r;

  logic in_load, advance;
  logic light_due, press_ok, press, retune, alarm_act, blink_due, report_due;
  logic [KNOB_W-1:0] knob_diff;
  logic signed [TEMP_W:0] temp_ext, fan_lo;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_load  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_load || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_comb begin
    light_due = (now_r - light_stamp_r) >= TIME_W'(light_per_r);
    light_stamp_nxt  = light_due ? now_r : light_stamp_r;
    lights_state_nxt = light_due ? (light_r < light_thr_r) : lights_state_r;

    press_ok = (button_r != button_last_r) &&
               ((now_r - debounce_stamp_r) > TIME_W'(debounce_r));
    press    = press_ok && button_r;
    debounce_stamp_nxt = press_ok ? now_r : debounce_stamp_r;
    button_last_nxt    = press_ok ? button_r : button_last_r;

    mode_nxt = mode_r;
    if (press) begin
      unique case (mode_r)
        MODE_FAN:   mode_nxt = MODE_ALARM;
        MODE_ALARM: mode_nxt = MODE_LIGHT;
        default:    mode_nxt = MODE_FAN;
      endcase
    end

    // a press resyncs the reference, so it never retunes in the same sample
    knob_diff = (knob_r > knob_ref_r) ? (knob_r - knob_ref_r) : (knob_ref_r - knob_r);
    retune = !press && knob_ref_valid_r && (knob_diff > deadband_r);
    knob_ref_nxt = (press || !knob_ref_valid_r || retune) ? knob_r : knob_ref_r;

    fan_thr_nxt   = fan_thr_r;
    cold_thr_nxt  = cold_thr_r;
    light_thr_nxt = light_thr_r;
    if (retune) begin
      unique case (mode_r)
        MODE_FAN:   fan_thr_nxt   = fan_cand_r;
        MODE_ALARM: cold_thr_nxt  = cold_cand_r;
        MODE_LIGHT: light_thr_nxt = knob_r;
        default:    ;
      endcase
    end

    temp_ext = {temp_r[TEMP_W-1], temp_r};
    fan_lo   = $signed({4'b0, fan_thr_nxt}) - $signed({6'b0, hyst_r});
    if (temp_ext >= $signed({4'b0, fan_thr_nxt})) begin
      fan_state_nxt = 1'b1;
    end else if (temp_ext < fan_lo) begin
      fan_state_nxt = 1'b0;
    end else begin
      fan_state_nxt = fan_state_r;
    end

    alarm_act = temp_ext < $signed({4'b0, cold_thr_nxt});
    blink_due = (now_r - blink_stamp_r) > TIME_W'(blink_per_r);
    led_state_nxt   = alarm_act ? (led_state_r ^ blink_due) : 1'b0;
    blink_stamp_nxt = (alarm_act && blink_due) ? now_r : blink_stamp_r;

    report_due = (now_r - report_stamp_r) >= TIME_W'(report_per_r);
    report_stamp_nxt = report_due ? now_r : report_stamp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      deadband_r   <= DEADBAND_RST;
      blink_per_r  <= BLINK_RST;
      light_per_r  <= LIGHT_RST;
      report_per_r <= REPORT_RST;
      hyst_r       <= HYST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_r   <= cfg_wdata;
        CFG_DEADBAND: deadband_r   <= cfg_wdata[KNOB_W-1:0];
        CFG_BLINK:    blink_per_r  <= cfg_wdata;
        CFG_LIGHT:    light_per_r  <= cfg_wdata;
        CFG_REPORT:   report_per_r <= cfg_wdata;
        CFG_HYST:     hyst_r       <= cfg_wdata[HYST_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      mode_r           <= MODE_FAN;
      button_last_r    <= 1'b0;
      debounce_stamp_r <= '0;
      knob_ref_valid_r <= 1'b0;
      fan_thr_r        <= FAN_THR_RST;
      cold_thr_r       <= COLD_THR_RST;
      light_thr_r      <= LIGHT_THR_RST;
      fan_state_r      <= 1'b0;
      led_state_r      <= 1'b0;
      blink_stamp_r    <= '0;
      light_stamp_r    <= '0;
      lights_state_r   <= 1'b0;
      report_stamp_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        mode_r           <= mode_nxt;
        button_last_r    <= button_last_nxt;
        debounce_stamp_r <= debounce_stamp_nxt;
        knob_ref_valid_r <= 1'b1;
        fan_thr_r        <= fan_thr_nxt;
        cold_thr_r       <= cold_thr_nxt;
        light_thr_r      <= light_thr_nxt;
        fan_state_r      <= fan_state_nxt;
        led_state_r      <= led_state_nxt;
        blink_stamp_r    <= blink_stamp_nxt;
        light_stamp_r    <= light_stamp_nxt;
        lights_state_r   <= lights_state_nxt;
        report_stamp_r   <= report_stamp_nxt;
      end
    end
  end

  // payload: sample word, knob reference and result word
  always_ff @(posedge clk) begin
    if (in_load) begin
      now_r       <= in_now_ms;
      temp_r      <= in_temperature;
      knob_r      <= in_knob_code;
      button_r    <= in_button_pressed;
      light_r     <= in_light_level;
      fan_cand_r  <= FAN_BASE + SET_W'(scale_up(in_knob_code, FAN_SPAN));
      cold_cand_r <= COLD_BASE + SET_W'(scale_up(in_knob_code, COLD_SPAN));
    end
    if (advance) begin
      knob_ref_r      <= knob_ref_nxt;
      out_fan_r       <= fan_state_nxt;
      out_led_r       <= led_state_nxt;
      out_lights_r    <= lights_state_nxt;
      out_mode_r      <= mode_nxt;
      out_mode_chg_r  <= press;
      out_report_r    <= report_due;
      out_fan_thr_r   <= fan_thr_nxt;
      out_cold_thr_r  <= cold_thr_nxt;
      out_light_thr_r <= light_thr_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fan_on         = out_fan_r;
  assign out_alarm_led      = out_led_r;
  assign out_lights_on      = out_lights_r;
  assign out_adjust_mode    = out_mode_r;
  assign out_mode_changed   = out_mode_chg_r;
  assign out_report_due     = out_report_r;
  assign out_fan_setpoint   = out_fan_thr_r;
  assign out_cold_setpoint  = out_cold_thr_r;
  assign out_light_setpoint = out_light_thr_r;

endmodule

[rtl/rtc_checker.sv]
`include "room_thermostat_controller_defines.svh"

module rtc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [1:0]                        out_adjust_mode,
  input logic [rtc_pkg::SET_W-1:0]         out_fan_setpoint,
  input logic [rtc_pkg::SET_W-1:0]         out_cold_setpoint,
  input logic [rtc_pkg::LIGHT_W-1:0]       out_light_setpoint
);
  import rtc_pkg::*;

  `RTC_ASSERT_NEXT(a_out_hold_valid, out_valid && out_stall, out_valid, "result word dropped under stall")

  `RTC_ASSERT_NEXT(a_out_hold_word, out_valid && out_stall, $stable(out_fan_setpoint) && $stable(out_cold_setpoint) && $stable(out_light_setpoint) && $stable(out_adjust_mode), "result word changed under stall")

  `RTC_ASSERT_NOW(a_fan_range, out_valid, (out_fan_setpoint >= FAN_BASE) && (out_fan_setpoint <= FAN_BASE + SET_W'(FAN_SPAN)), "fan setpoint out of range")

  `RTC_ASSERT_NOW(a_cold_range, out_valid, (out_cold_setpoint >= COLD_BASE) && (out_cold_setpoint <= COLD_BASE + SET_W'(COLD_SPAN)), "cold setpoint out of range")

  `RTC_ASSERT_NOW(a_no_stall_empty, !out_valid, !in_stall, "input stalled with the result register empty")

endmodule

bind room_thermostat_controller rtc_checker u_rtc_checker (.*);
